/* hdl/arr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arr_pkg
// Shared constants and types for the address range allocator: command and
// status codes, configuration register indexes, shared unit operations.
// ----------------------------------------------------------------------------
package arr_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int ADDR_BITS_DEF     = 32;

    // Width of every address field on the ports
    localparam int FIELD_W   = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_END   = 1'd1;

    localparam logic [1:0] CMD_REQUEST  = 2'd0;
    localparam logic [1:0] CMD_RELEASE  = 2'd1;
    localparam logic [1:0] CMD_ALLOCATE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BUSY      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

endpackage

/* hdl/arr_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arr_alu
// Shared add / subtract unit. Subtract also yields an unsigned less-than
// flag from the borrow and a zero flag for equality tests.
// ----------------------------------------------------------------------------
module arr_alu #(
    parameter int ADDR_BITS = arr_pkg::ADDR_BITS_DEF
) (
    input  logic [ADDR_BITS-1:0] op_a,
    input  logic [ADDR_BITS-1:0] op_b,
    input  arr_pkg::alu_op_t     op,
    output logic [ADDR_BITS-1:0] res,
    output logic                 lt,
    output logic                 zero
);
    import arr_pkg::*;

    logic                 is_sub;
    logic [ADDR_BITS-1:0] b_in;
    logic [ADDR_BITS:0]   sum;

    assign is_sub = (op == ALU_SUB);
    assign b_in   = is_sub ? ~op_b : op_b;
    assign sum    = {1'b0, op_a} + {1'b0, b_in} + {{ADDR_BITS{1'b0}}, is_sub};
    assign res    = sum[ADDR_BITS-1:0];
    // no carry out of a - b means a borrow, so a < b
    assign lt     = is_sub & ~sum[ADDR_BITS];
    assign zero   = (res == '0);

endmodule

/* hdl/arr_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arr_table
// Range table memory: one write port, one read port with registered data.
// Each word holds the first address in the upper half, the last in the lower.
// ----------------------------------------------------------------------------
module arr_table #(
    parameter int TABLE_ENTRIES = arr_pkg::TABLE_ENTRIES_DEF,
    parameter int ADDR_BITS     = arr_pkg::ADDR_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               we,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]   waddr,
    input  logic [2*ADDR_BITS-1:0]             wdata,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]   raddr,
    output logic [2*ADDR_BITS-1:0]             rdata
);
    logic [2*ADDR_BITS-1:0] mem_reg [TABLE_ENTRIES];
    logic [2*ADDR_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/arr_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arr_seq
// Command sequencer: walks the sorted range table one entry per step, shifts
// entries on insert and remove, and runs the first-fit gap search, all
// through one shared add / subtract unit.
// ----------------------------------------------------------------------------
module arr_seq #(
    parameter int TABLE_ENTRIES = arr_pkg::TABLE_ENTRIES_DEF,
    parameter int ADDR_BITS     = arr_pkg::ADDR_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           command,
    input  logic [ADDR_BITS-1:0] range_start,
    input  logic [ADDR_BITS-1:0] range_end,
    input  logic [ADDR_BITS-1:0] alloc_size,
    input  logic [ADDR_BITS-1:0] min_addr,
    input  logic [ADDR_BITS-1:0] max_addr,
    input  logic [ADDR_BITS-1:0] align,
    input  logic [ADDR_BITS-1:0] region_start,
    input  logic [ADDR_BITS-1:0] region_end,
    output logic                 done,
    output logic [1:0]           status,
    output logic [ADDR_BITS-1:0] granted_start,
    output logic [ADDR_BITS-1:0] granted_end
);
    import arr_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0]     FULL_CNT = CNT_W'(TABLE_ENTRIES);
    localparam logic [ADDR_BITS-1:0] ONE      = ADDR_BITS'(1);

    typedef enum logic [4:0] {
        S_IDLE,
        S_C_REV,
        S_C_LO,
        S_C_HI,
        S_C_SCANF,
        S_C_SCANL,
        S_C_FULL,
        S_SH_PRIME,
        S_SH_RUN,
        S_INS,
        S_RL_CMP,
        S_DN_PRIME,
        S_DN_RUN,
        S_DN_FIN,
        S_A_MASK,
        S_A_LO,
        S_A_HI,
        S_A_RND,
        S_A_FIT1,
        S_A_FIT2,
        S_A_FIT3,
        S_A_FIT4,
        S_A_END1,
        S_A_END2,
        S_A_NEXT
    } state_t;

    state_t               state_reg, state_next;
    logic [1:0]           cmd_reg, cmd_next;
    logic [ADDR_BITS-1:0] cs_reg, cs_next;
    logic [ADDR_BITS-1:0] ce_reg, ce_next;
    logic [ADDR_BITS-1:0] size_reg, size_next;
    logic [ADDR_BITS-1:0] lo_reg, lo_next;
    logic [ADDR_BITS-1:0] hi_reg, hi_next;
    logic [ADDR_BITS-1:0] amask_reg, amask_next;
    logic [ADDR_BITS-1:0] tmp_reg, tmp_next;
    logic [CNT_W-1:0]     pos_reg, pos_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic [CNT_W-1:0]     used_reg, used_next;
    logic                 done_reg, done_next;
    logic [1:0]           status_reg, status_next;
    logic [ADDR_BITS-1:0] gs_reg, gs_next;
    logic [ADDR_BITS-1:0] ge_reg, ge_next;

    logic [ADDR_BITS-1:0]   alu_a, alu_b, alu_res;
    alu_op_t                alu_op;
    logic                   alu_lt, alu_zero;

    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr, mem_raddr;
    logic [2*ADDR_BITS-1:0] mem_wdata, mem_rdata;
    logic [ADDR_BITS-1:0]   rd_first, rd_last, end_src;

    logic [CNT_W-1:0]       pos_inc, k_dec, k_dec2;
    logic [CNT_W:0]         k_inc, k_inc2, used_ext;
    logic                   last_gap;
    logic                   fin;
    logic [1:0]             fin_status;

    arr_alu #(
        .ADDR_BITS(ADDR_BITS)
    ) u_alu (
        .op_a (alu_a),
        .op_b (alu_b),
        .op   (alu_op),
        .res  (alu_res),
        .lt   (alu_lt),
        .zero (alu_zero)
    );

    arr_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .ADDR_BITS    (ADDR_BITS)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_first = mem_rdata[2*ADDR_BITS-1:ADDR_BITS];
    assign rd_last  = mem_rdata[ADDR_BITS-1:0];

    assign pos_inc  = pos_reg + CNT_W'(1);
    assign k_dec    = k_reg - CNT_W'(1);
    assign k_dec2   = k_reg - CNT_W'(2);
    assign k_inc    = {1'b0, k_reg} + (CNT_W+1)'(1);
    assign k_inc2   = {1'b0, k_reg} + (CNT_W+1)'(2);
    assign used_ext = {1'b0, used_reg};
    // past the last claimed range the gap runs to the region end
    assign last_gap = (pos_reg >= used_reg);
    assign end_src  = last_gap ? region_end : rd_first;

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        cs_next     = cs_reg;
        ce_next     = ce_reg;
        size_next   = size_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        amask_next  = amask_reg;
        tmp_next    = tmp_reg;
        pos_next    = pos_reg;
        k_next      = k_reg;
        used_next   = used_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        gs_next     = gs_reg;
        ge_next     = ge_reg;

        alu_a      = cs_reg;
        alu_b      = ce_reg;
        alu_op     = ALU_SUB;
        mem_we     = 1'b0;
        mem_waddr  = k_reg[IDX_W-1:0];
        mem_wdata  = mem_rdata;
        mem_raddr  = pos_reg[IDX_W-1:0];
        fin        = 1'b0;
        fin_status = ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                mem_raddr = '0;
                if (start)
                begin
                    cmd_next   = command;
                    cs_next    = range_start;
                    ce_next    = range_end;
                    size_next  = alloc_size;
                    lo_next    = min_addr;
                    hi_next    = max_addr;
                    amask_next = align;
                    pos_next   = '0;
                    unique case (command)
                        CMD_REQUEST:  state_next = S_C_REV;
                        CMD_RELEASE:  state_next = S_RL_CMP;
                        CMD_ALLOCATE: state_next = S_A_MASK;
                        default:
                        begin
                            fin        = 1'b1;
                            fin_status = ST_BUSY;
                        end
                    endcase
                end
            end

            // ---- claim: bounds, overlap scan, shift up, insert ----
            S_C_REV:
            begin
                alu_a = ce_reg;
                alu_b = cs_reg;
                if (alu_lt)
                begin
                    fin        = 1'b1;
                    fin_status = ST_BUSY;
                end
                else
                begin
                    state_next = S_C_LO;
                end
            end

            S_C_LO:
            begin
                alu_a = cs_reg;
                alu_b = region_start;
                if (alu_lt)
                begin
                    fin        = 1'b1;
                    fin_status = ST_BUSY;
                end
                else
                begin
                    state_next = S_C_HI;
                end
            end

            S_C_HI:
            begin
                alu_a     = region_end;
                alu_b     = ce_reg;
                mem_raddr = '0;
                pos_next  = '0;
                if (alu_lt)
                begin
                    fin        = 1'b1;
                    fin_status = ST_BUSY;
                end
                else
                begin
                    state_next = S_C_SCANF;
                end
            end

            S_C_SCANF:
            begin
                alu_a = ce_reg;
                alu_b = rd_first;
                // stop at the first range that starts past our end
                if (last_gap || alu_lt)
                begin
                    state_next = S_C_FULL;
                end
                else
                begin
                    state_next = S_C_SCANL;
                end
            end

            S_C_SCANL:
            begin
                alu_a = rd_last;
                alu_b = cs_reg;
                if (!alu_lt)
                begin
                    fin        = 1'b1;
                    fin_status = ST_BUSY;
                end
                else
                begin
                    pos_next   = pos_inc;
                    mem_raddr  = pos_inc[IDX_W-1:0];
                    state_next = S_C_SCANF;
                end
            end

            S_C_FULL:
            begin
                if (used_reg == FULL_CNT)
                begin
                    fin        = 1'b1;
                    fin_status = ST_FULL;
                end
                else
                begin
                    k_next     = used_reg;
                    state_next = S_SH_PRIME;
                end
            end

            S_SH_PRIME:
            begin
                if (k_reg > pos_reg)
                begin
                    mem_raddr  = k_dec[IDX_W-1:0];
                    state_next = S_SH_RUN;
                end
                else
                begin
                    state_next = S_INS;
                end
            end

            S_SH_RUN:
            begin
                // move entry k-1 up to k while fetching k-2
                mem_we    = 1'b1;
                mem_waddr = k_reg[IDX_W-1:0];
                mem_wdata = mem_rdata;
                k_next    = k_dec;
                if (k_dec > pos_reg)
                begin
                    mem_raddr = k_dec2[IDX_W-1:0];
                end
                else
                begin
                    state_next = S_INS;
                end
            end

            S_INS:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg[IDX_W-1:0];
                mem_wdata  = {cs_reg, ce_reg};
                used_next  = used_reg + CNT_W'(1);
                fin        = 1'b1;
                fin_status = ST_OK;
            end

            // ---- release: match scan, shift down ----
            S_RL_CMP:
            begin
                alu_a = rd_first;
                alu_b = cs_reg;
                if (last_gap)
                begin
                    fin        = 1'b1;
                    fin_status = ST_NOT_FOUND;
                end
                else if (alu_zero)
                begin
                    k_next     = pos_reg;
                    state_next = S_DN_PRIME;
                end
                else
                begin
                    pos_next  = pos_inc;
                    mem_raddr = pos_inc[IDX_W-1:0];
                end
            end

            S_DN_PRIME:
            begin
                if (k_inc < used_ext)
                begin
                    mem_raddr  = k_inc[IDX_W-1:0];
                    state_next = S_DN_RUN;
                end
                else
                begin
                    state_next = S_DN_FIN;
                end
            end

            S_DN_RUN:
            begin
                // move entry k+1 down to k while fetching k+2
                mem_we    = 1'b1;
                mem_waddr = k_reg[IDX_W-1:0];
                mem_wdata = mem_rdata;
                k_next    = k_inc[CNT_W-1:0];
                if (k_inc2 < used_ext)
                begin
                    mem_raddr = k_inc2[IDX_W-1:0];
                end
                else
                begin
                    state_next = S_DN_FIN;
                end
            end

            S_DN_FIN:
            begin
                used_next  = used_reg - CNT_W'(1);
                fin        = 1'b1;
                fin_status = ST_OK;
            end

            // ---- allocate: first-fit gap search ----
            S_A_MASK:
            begin
                alu_a      = amask_reg;
                alu_b      = ONE;
                amask_next = alu_res;
                cs_next    = region_start;
                pos_next   = '0;
                state_next = S_A_LO;
            end

            S_A_LO:
            begin
                alu_a = cs_reg;
                alu_b = lo_reg;
                if (alu_lt)
                begin
                    cs_next = lo_reg;
                end
                state_next = S_A_HI;
            end

            S_A_HI:
            begin
                alu_a      = hi_reg;
                alu_b      = end_src;
                ce_next    = alu_lt ? hi_reg : end_src;
                state_next = S_A_RND;
            end

            S_A_RND:
            begin
                alu_a      = cs_reg;
                alu_b      = amask_reg;
                alu_op     = ALU_ADD;
                cs_next    = alu_res & ~amask_reg;
                state_next = S_A_FIT1;
            end

            S_A_FIT1:
            begin
                alu_a = cs_reg;
                alu_b = ce_reg;
                if (alu_lt)
                begin
                    state_next = S_A_FIT2;
                end
                else if (last_gap)
                begin
                    fin        = 1'b1;
                    fin_status = ST_BUSY;
                end
                else
                begin
                    state_next = S_A_NEXT;
                end
            end

            S_A_FIT2:
            begin
                alu_a      = ce_reg;
                alu_b      = cs_reg;
                tmp_next   = alu_res;
                state_next = S_A_FIT3;
            end

            S_A_FIT3:
            begin
                alu_a      = tmp_reg;
                alu_b      = ONE;
                alu_op     = ALU_ADD;
                tmp_next   = alu_res;
                state_next = S_A_FIT4;
            end

            S_A_FIT4:
            begin
                alu_a = tmp_reg;
                alu_b = size_reg;
                if (!alu_lt)
                begin
                    state_next = S_A_END1;
                end
                else if (last_gap)
                begin
                    fin        = 1'b1;
                    fin_status = ST_BUSY;
                end
                else
                begin
                    state_next = S_A_NEXT;
                end
            end

            S_A_END1:
            begin
                alu_a      = cs_reg;
                alu_b      = size_reg;
                alu_op     = ALU_ADD;
                tmp_next   = alu_res;
                state_next = S_A_END2;
            end

            S_A_END2:
            begin
                // the chosen range then goes through the normal claim
                alu_a      = tmp_reg;
                alu_b      = ONE;
                ce_next    = alu_res;
                state_next = S_C_REV;
            end

            S_A_NEXT:
            begin
                alu_a      = rd_last;
                alu_b      = ONE;
                alu_op     = ALU_ADD;
                cs_next    = alu_res;
                pos_next   = pos_inc;
                state_next = S_A_LO;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next  = S_IDLE;
            done_next   = 1'b1;
            status_next = fin_status;
            gs_next     = '0;
            ge_next     = '0;
            if (fin_status == ST_OK && cmd_reg == CMD_ALLOCATE)
            begin
                gs_next = cs_reg;
                ge_next = ce_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cmd_reg    <= CMD_REQUEST;
            cs_reg     <= '0;
            ce_reg     <= '0;
            size_reg   <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            amask_reg  <= '0;
            tmp_reg    <= '0;
            pos_reg    <= '0;
            k_reg      <= '0;
            used_reg   <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            gs_reg     <= '0;
            ge_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cmd_reg    <= cmd_next;
            cs_reg     <= cs_next;
            ce_reg     <= ce_next;
            size_reg   <= size_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            amask_reg  <= amask_next;
            tmp_reg    <= tmp_next;
            pos_reg    <= pos_next;
            k_reg      <= k_next;
            used_reg   <= used_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            gs_reg     <= gs_next;
            ge_reg     <= ge_next;
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign granted_start = gs_reg;
    assign granted_end   = ge_reg;

endmodule

/* hdl/address_range_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_range_allocator
// Pulse start while busy is low to issue a command (request, release or
// allocate). The block raises busy once it has taken the command and keeps
// it up until the result is ready; an unknown command code is answered with
// status busy and busy does not rise. The result appears on status /
// granted_start / granted_end with done high for exactly one cycle and holds
// until the next result; busy is already low in that cycle, so the next
// command may start alongside it. Nothing holds the result back: capture it
// on done. Each command walks the range table through a single add /
// subtract unit and a one-port-read table memory: request checks bounds,
// scans for overlap, checks for room, shifts ranges up and inserts; release
// scans for the match and shifts ranges down; allocate sets up, tests each
// gap first-fit, then runs the request path on the gap that fits. The table
// needs no clearing after reset. The user must write the region registers
// through the cfg port only while no command runs; the block does not enforce it.
// ----------------------------------------------------------------------------
module address_range_allocator #(
    parameter int TABLE_ENTRIES = arr_pkg::TABLE_ENTRIES_DEF,
    parameter int ADDR_BITS     = arr_pkg::ADDR_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    command,
    input  logic [arr_pkg::FIELD_W-1:0]   range_start,
    input  logic [arr_pkg::FIELD_W-1:0]   range_end,
    input  logic [arr_pkg::FIELD_W-1:0]   alloc_size,
    input  logic [arr_pkg::FIELD_W-1:0]   min_addr,
    input  logic [arr_pkg::FIELD_W-1:0]   max_addr,
    input  logic [arr_pkg::FIELD_W-1:0]   align,
    output logic                          done,
    output logic [1:0]                    status,
    output logic [arr_pkg::FIELD_W-1:0]   granted_start,
    output logic [arr_pkg::FIELD_W-1:0]   granted_end,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [arr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [arr_pkg::FIELD_W-1:0]   cfg_data
);
    import arr_pkg::*;

    logic [ADDR_BITS-1:0] region_start_reg;
    logic [ADDR_BITS-1:0] region_end_reg;
    logic [ADDR_BITS-1:0] gs_int, ge_int;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_start_reg <= '0;
            region_end_reg   <= ADDR_BITS'({FIELD_W{1'b1}});
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_REGION_START: region_start_reg <= ADDR_BITS'(cfg_data);
                REG_REGION_END:   region_end_reg   <= ADDR_BITS'(cfg_data);
                default:
                begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    arr_seq #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .ADDR_BITS    (ADDR_BITS)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .range_start   (ADDR_BITS'(range_start)),
        .range_end     (ADDR_BITS'(range_end)),
        .alloc_size    (ADDR_BITS'(alloc_size)),
        .min_addr      (ADDR_BITS'(min_addr)),
        .max_addr      (ADDR_BITS'(max_addr)),
        .align         (ADDR_BITS'(align)),
        .region_start  (region_start_reg),
        .region_end    (region_end_reg),
        .done          (done),
        .status        (status),
        .granted_start (gs_int),
        .granted_end   (ge_int)
    );

    assign granted_start = FIELD_W'(gs_int);
    assign granted_end   = FIELD_W'(ge_int);

endmodule
